>>> rtl/sahtr_pkg.sv
// ----------------------------------------------------------------------------
// sahtr_pkg
// Shared types and constants of the set-associative hash table with
// depth/generation replacement.
// ----------------------------------------------------------------------------
package sahtr_pkg;

	localparam int INDEX_BITS_DEF = 10;
	localparam int WAYS_DEF       = 4;

	// Widest bucket index that the queue carries; INDEX_BITS must not exceed it.
	localparam int KEY_IDX_W   = 24;
	localparam int TAG_W       = 32;
	localparam int GEN_W       = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam int S_TDATA_W = 112;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 1;

	localparam logic [GEN_W-1:0] GEN_RESET = 6'd1;

	typedef enum logic [1:0] {
		MODE_SAVE       = 2'd0,
		MODE_PROBE      = 2'd1,
		MODE_NEW_SEARCH = 2'd2,
		MODE_CLEAR      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} back_state_t;

	// The move sits in the lowest bits so that this struct is the output beat as is.
	typedef struct packed {
		logic [GEN_W-1:0]   gen;
		logic [1:0]         flags;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic [15:0]        mv;
	} result_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		result_t          body;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		mode_t                mode;
		logic                 needs_read;
		logic [TAG_W-1:0]     tag;
		logic [KEY_IDX_W-1:0] idx;
		logic [15:0]          mv;
		logic signed [15:0]   score;
		logic signed [7:0]    depth;
		logic [1:0]           flags;
	} op_t;

	typedef struct packed {
		logic clearing;
		logic exec;
	} back_stat_t;

endpackage

>>> rtl/sahtr_ram.sv
// ----------------------------------------------------------------------------
// sahtr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module sahtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/sahtr_front.sv
// ----------------------------------------------------------------------------
// sahtr_front
// Input side: takes beats from the slave stream, splits them into an
// operation record, marks which operations need a bucket read, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module sahtr_front import sahtr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// key[63:0], best_move[79:64], score[95:80], search_depth[103:96],
	// bound_flags[105:104], zero pad[111:106]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 op_valid,
	input  logic                 op_ready,
	output op_t                  op
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	op_t              in_op;
	logic             push;
	logic             pop;

	always_comb begin
		in_op.mode       = mode_t'(s_tuser[1:0]);
		in_op.needs_read = (in_op.mode == MODE_SAVE) || (in_op.mode == MODE_PROBE);
		in_op.idx        = s_tdata[KEY_IDX_W-1:0];
		in_op.tag        = s_tdata[63:32];
		in_op.mv         = s_tdata[79:64];
		in_op.score      = s_tdata[95:80];
		in_op.depth      = s_tdata[103:96];
		in_op.flags      = s_tdata[105:104];
	end

	assign s_tready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign op_valid = (count_q != '0);
	assign op       = slot_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/sahtr_back.sv
// ----------------------------------------------------------------------------
// sahtr_back
// Execution side: reads one bucket row, picks the matching or the
// replacement way, writes the row back for a save, and presents the result in an
// output register. Also runs the clearing sweep and keeps the generation.
// ----------------------------------------------------------------------------
module sahtr_back import sahtr_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int WAYS       = WAYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_ready,
	input  op_t                  op,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	output back_stat_t           stat
);

	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NP      = 1 << WAY_W;
	localparam int ROW_W   = WAYS * ENTRY_W;
	localparam int BUCKETS = 1 << INDEX_BITS;
	localparam int RKEY_W  = 9;

	back_state_t           state_q, state_d;
	logic [INDEX_BITS-1:0] clr_q, clr_d;
	logic [GEN_W-1:0]      gen_q, gen_d;
	op_t                   op_q;
	logic                  out_valid_q;
	logic                  out_hit_q;
	result_t               out_body_q;

	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	logic [ROW_W-1:0]      ram_wdata;
	logic                  ram_re;
	logic [INDEX_BITS-1:0] ram_raddr;
	logic [ROW_W-1:0]      ram_rdata;

	entry_t                way_e [WAYS];
	logic [WAYS-1:0]       tag_eq;
	logic                  match_any;
	logic [WAY_W-1:0]      match_idx;
	logic [RKEY_W-1:0]     t_key [2*NP];
	logic [WAY_W-1:0]      t_idx [2*NP];
	logic [WAY_W-1:0]      sel_idx;
	entry_t                sel_e;
	entry_t                new_e;
	logic [ROW_W-1:0]      new_row;
	logic                  out_free;
	logic                  load_out;
	logic                  res_hit;
	result_t               res_body;

	sahtr_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			way_e[w]  = ram_rdata[w*ENTRY_W +: ENTRY_W];
			tag_eq[w] = (way_e[w].tag == op_q.tag);
		end
		match_any = |tag_eq;
		match_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (tag_eq[w]) begin
				match_idx = WAY_W'(w);
			end
		end
	end

	// Victim choice: the lowest way with the smallest {is current generation,
	// depth}. The depth is biased so that signed order becomes unsigned order.
	// Ties go to the left child, which keeps the lower way.
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			if (i < WAYS) begin
				t_key[NP+i] = {(way_e[i].body.gen == gen_q), ~way_e[i].body.depth[7],
					way_e[i].body.depth[6:0]};
			end else begin
				t_key[NP+i] = '1;
			end
			t_idx[NP+i] = WAY_W'(i);
		end
		t_key[0] = '0;
		t_idx[0] = '0;
		for (int n = NP - 1; n >= 1; n--) begin
			if (t_key[2*n+1] < t_key[2*n]) begin
				t_key[n] = t_key[2*n+1];
				t_idx[n] = t_idx[2*n+1];
			end else begin
				t_key[n] = t_key[2*n];
				t_idx[n] = t_idx[2*n];
			end
		end
	end

	always_comb begin
		sel_idx          = match_any ? match_idx : t_idx[1];
		sel_e            = way_e[sel_idx];
		new_e.tag        = op_q.tag;
		new_e.body.mv    = (match_any && (op_q.mv == '0)) ? sel_e.body.mv : op_q.mv;
		new_e.body.score = op_q.score;
		new_e.body.depth = op_q.depth;
		new_e.body.flags = op_q.flags;
		new_e.body.gen   = gen_q;
		for (int w = 0; w < WAYS; w++) begin
			new_row[w*ENTRY_W +: ENTRY_W] = (WAY_W'(w) == sel_idx) ? new_e : way_e[w];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		gen_d     = gen_q;
		op_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = op.idx[INDEX_BITS-1:0];
		ram_we    = 1'b0;
		ram_waddr = op_q.idx[INDEX_BITS-1:0];
		ram_wdata = new_row;
		load_out  = 1'b0;
		res_hit   = 1'b0;
		res_body  = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				op_ready = 1'b1;
				if (op_valid) begin
					ram_re  = op.needs_read;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
					case (op_q.mode)
						MODE_SAVE: begin
							ram_we   = 1'b1;
							res_hit  = match_any;
							res_body = new_e.body;
						end
						MODE_PROBE: begin
							if (match_any) begin
								res_hit  = 1'b1;
								res_body = sel_e.body;
							end
						end
						MODE_NEW_SEARCH: begin
							gen_d = gen_q + 1'b1;
						end
						MODE_CLEAR: begin
							gen_d   = GEN_RESET;
							state_d = ST_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			gen_q       <= GEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			gen_q   <= gen_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			op_q <= op;
		end
		if (load_out) begin
			out_hit_q  <= res_hit;
			out_body_q <= res_body;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_body_q;
	assign m_tuser       = out_hit_q;
	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.exec     = (state_q == ST_EXEC);

endmodule

>>> rtl/set_assoc_hash_table_replace.sv
// ----------------------------------------------------------------------------
// set_assoc_hash_table_replace
// Set-associative hash table of search results with tag match, keep-move
// on overwrite and generation/depth victim choice.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                                   | tuser
//  s_*     | in        | key, best_move, score, depth, flags     | mode
//  m_*     | out       | move, score, depth, flags, generation   | hit
//
// In the back end an item first reads its bucket row from the single row RAM
// (save and probe only), then updates it and, for a save, writes that row back;
// the next item's read starts after that. A two-deep queue decouples input.
// After reset, and after a clear item, a sweep zeroes the RAM one row a cycle;
// no item leaves the queue during the sweep.
// A stalled output holds its beat and holds the back end in its update cycle.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_replace import sahtr_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int WAYS       = WAYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// key[63:0], best_move[79:64], score[95:80], search_depth[103:96],
	// bound_flags[105:104], zero pad[111:106]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// found_move[15:0], found_score[31:16], found_depth[39:32],
	// found_flags[41:40], found_generation[47:42]
	output logic [M_TDATA_W-1:0] m_tdata,
	// hit[0]
	output logic [M_TUSER_W-1:0] m_tuser
);

	logic       op_valid;
	logic       op_ready;
	op_t        op;
	back_stat_t stat;

	sahtr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.op      (op)
	);

	sahtr_back #(
		.INDEX_BITS(INDEX_BITS),
		.WAYS      (WAYS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.op      (op),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.stat    (stat)
	);

	// No operation may leave the queue while the sweep is still zeroing rows.
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !(op_valid && op_ready))
		else $error("operation taken during clearing sweep");

	// A taken operation is executed in the following cycle.
	a_pop_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && op_ready) |=> stat.exec)
		else $error("taken operation did not reach execution");

	// A new result beat only ever comes out of the update cycle.
	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(stat.exec))
		else $error("result beat appeared outside execution");

endmodule
